// File: rtl/sosg_pkg.sv
// Shared constants, types and tables of the sine oscillator sample generator.
package sosg_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int PHASE_BITS  = 32;

  localparam int INC_W     = 32;
  localparam int AMP_W     = 16;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_PHASE_INC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_AMPLITUDE = CFG_IDX_W'(1);

  localparam logic [INC_W-1:0] PHASE_INC_RST = INC_W'(89478485);
  localparam logic [AMP_W-1:0] AMPLITUDE_RST = AMP_W'(32768);

  localparam int CORDIC_STEPS = 30;
  localparam int STEP_W       = $clog2(CORDIC_STEPS);
  localparam int XY_W         = 34;
  localparam int ATAN_W       = 30;
  localparam int FRAC_BITS    = 30;

  localparam logic [XY_W-1:0] CORDIC_GAIN = XY_W'(32'h26DD3B6A);
  localparam logic [XY_W-1:0] ONE_Q30     = XY_W'(64'd1 << FRAC_BITS);

  localparam int MUL_W  = 32;
  localparam int PROD_W = 2 * MUL_W;

  localparam logic [MUL_W-1:0] HALF_PI_Q30 = MUL_W'(32'h6487ED51);
  localparam logic [MUL_W-1:0] SAMPLE_MAX  = MUL_W'((64'd1 << (SAMPLE_BITS - 1)) - 64'd1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ZMUL,
    S_ROT,
    S_GMUL,
    S_MMUL
  } state_t;

  function automatic logic [ATAN_W-1:0] atan_q30(input logic [STEP_W-1:0] idx);
    logic [ATAN_W-1:0] v;
    case (idx)
      5'd0:  v = 30'h3243F6A8;
      5'd1:  v = 30'h1DAC6705;
      5'd2:  v = 30'h0FADBAFC;
      5'd3:  v = 30'h07F56EA6;
      5'd4:  v = 30'h03FEAB76;
      5'd5:  v = 30'h01FFD55B;
      5'd6:  v = 30'h00FFFAAA;
      5'd7:  v = 30'h007FFF55;
      5'd8:  v = 30'h003FFFEA;
      5'd9:  v = 30'h001FFFFD;
      5'd10: v = 30'h000FFFFF;
      5'd11: v = 30'h0007FFFF;
      5'd12: v = 30'h0003FFFF;
      5'd13: v = 30'h0001FFFF;
      5'd14: v = 30'h0000FFFF;
      5'd15: v = 30'h00007FFF;
      5'd16: v = 30'h00003FFF;
      5'd17: v = 30'h00001FFF;
      5'd18: v = 30'h00000FFF;
      5'd19: v = 30'h000007FF;
      5'd20: v = 30'h000003FF;
      5'd21: v = 30'h000001FF;
      5'd22: v = 30'h000000FF;
      5'd23: v = 30'h0000007F;
      5'd24: v = 30'h0000003F;
      5'd25: v = 30'h0000001F;
      5'd26: v = 30'h0000000F;
      5'd27: v = 30'h00000008;
      5'd28: v = 30'h00000004;
      5'd29: v = 30'h00000002;
      default: v = '0;
    endcase
    return v;
  endfunction

  // top 32 bits of the phase, zero filled below for narrow phase words
  function automatic logic [31:0] phase_top32(input logic [PHASE_BITS-1:0] p);
    logic [63:0] w;
    w = {p, {(64 - PHASE_BITS){1'b0}}};
    return w[63:32];
  endfunction

endpackage

// File: rtl/sine_oscillator_sample_generator.sv
// Top level of the sine oscillator sample generator: sequencer, shared multiplier, phase.
//
// Each input item (in_valid/in_stall, field in_restart) requests one audio sample.
// in_restart = 1 clears the phase before the sample is formed. The result item
// (out_valid/out_stall, field out_sample) is the signed sample
// trunc(amplitude * sin(phase) * (2^(SAMPLE_BITS-1)-1)); after each sample the
// phase advances by phase_increment, wrapping.
// Configuration: cfg_we writes cfg_data into register cfg_index
// (0 = phase_increment, 1 = amplitude Q0.16); other indexes are ignored.
// One shared 32x32 multiplier forms the angle, the gain and the scaling, and a
// 30-step iterative CORDIC does the rotation. in_stall is high from acceptance
// until the sample has been loaded into the output register, so a new item is
// not taken before the last one has been loaded.
// The output register holds the sample while out_stall is high; the sequencer
// then waits in its last step until the register is free.
// Reset: phase zero, phase_increment 89478485, amplitude 0.5, no item in flight.
module sine_oscillator_sample_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_valid,
  output logic                                  in_stall,
  input  logic                                  in_restart,
  output logic                                  out_valid,
  input  logic                                  out_stall,
  output logic signed [sosg_pkg::SAMPLE_BITS-1:0] out_sample,
  input  logic                                  cfg_we,
  input  logic [sosg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [sosg_pkg::CFG_W-1:0]            cfg_data
);
  import sosg_pkg::*;

  state_t state_r, state_nxt;

  logic [INC_W-1:0]      phase_inc_r;
  logic [AMP_W-1:0]      amplitude_r;
  logic [PHASE_BITS-1:0] phase_r, phase_sel;
  logic [31:0]           t_r;
  logic [PROD_W-1:0]     prod_r, prod;
  logic [MUL_W-1:0]      mul_a, mul_b;
  logic                  in_acc;
  logic                  out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r;
  logic [SAMPLE_BITS-1:0] mag, smp;
  logic                  load_out;
  logic                  cordic_start, cordic_done;
  logic signed [XY_W-1:0] z0, cx, cy, m_sel;
  logic [XY_W-1:0]       m;

  sosg_cordic u_cordic (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cordic_start),
    .z0    (z0),
    .x     (cx),
    .y     (cy),
    .done  (cordic_done)
  );

  assign in_stall = (state_r != S_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign phase_sel = in_restart ? '0 : phase_r;

  always_comb begin
    m_sel = t_r[30] ? cx : cy;
    if (m_sel[XY_W-1]) begin
      m = '0;
    end else if ($unsigned(m_sel) > ONE_Q30) begin
      m = ONE_Q30;
    end else begin
      m = $unsigned(m_sel);
    end
  end

  always_comb begin
    state_nxt    = state_r;
    mul_a        = '0;
    mul_b        = '0;
    cordic_start = 1'b0;
    load_out     = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          state_nxt = S_ZMUL;
        end
      end
      S_ZMUL: begin
        mul_a        = MUL_W'(t_r[29:0]);
        mul_b        = HALF_PI_Q30;
        cordic_start = 1'b1;
        state_nxt    = S_ROT;
      end
      S_ROT: begin
        if (cordic_done) begin
          state_nxt = S_GMUL;
        end
      end
      S_GMUL: begin
        mul_a     = MUL_W'(amplitude_r);
        mul_b     = MUL_W'(m);
        state_nxt = S_MMUL;
      end
      S_MMUL: begin
        mul_a = MUL_W'(prod_r >> AMP_W);
        mul_b = SAMPLE_MAX;
        if (!out_valid_r || !out_stall) begin
          load_out  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign prod = PROD_W'(mul_a) * PROD_W'(mul_b);
  assign z0   = $signed(XY_W'(prod >> FRAC_BITS));
  assign mag  = SAMPLE_BITS'(prod >> FRAC_BITS);
  assign smp  = t_r[31] ? (SAMPLE_BITS'(0) - mag) : mag;

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (load_out) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      phase_inc_r <= PHASE_INC_RST;
      amplitude_r <= AMPLITUDE_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      if (in_acc) begin
        phase_r <= PHASE_BITS'(64'(phase_sel) + 64'(phase_inc_r));
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_PHASE_INC: phase_inc_r <= INC_W'(cfg_data);
          REG_AMPLITUDE: amplitude_r <= AMP_W'(cfg_data);
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      t_r <= phase_top32(phase_sel);
    end
    if (state_r == S_GMUL) begin
      prod_r <= prod;
    end
    if (load_out) begin
      out_sample_r <= $signed(smp);
    end
  end

  assign out_valid  = out_valid_r;
  assign out_sample = out_sample_r;

endmodule

// File: rtl/sosg_cordic.sv
// Iterative CORDIC rotation: one micro-rotation per cycle on a shared add/shift unit.
module sosg_cordic (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic signed [sosg_pkg::XY_W-1:0] z0,
  output logic signed [sosg_pkg::XY_W-1:0] x,
  output logic signed [sosg_pkg::XY_W-1:0] y,
  output logic                           done
);
  import sosg_pkg::*;

  logic signed [XY_W-1:0] x_r, y_r, z_r;
  logic signed [XY_W-1:0] x_nxt, y_nxt, z_nxt;
  logic signed [XY_W-1:0] xs, ys, at;
  logic [STEP_W-1:0]      i_r;
  logic                   busy_r, done_r;
  logic                   last;

  always_comb begin
    xs    = x_r >>> i_r;
    ys    = y_r >>> i_r;
    at    = $signed(XY_W'(atan_q30(i_r)));
    if (!z_r[XY_W-1]) begin
      x_nxt = x_r - ys;
      y_nxt = y_r + xs;
      z_nxt = z_r - at;
    end else begin
      x_nxt = x_r + ys;
      y_nxt = y_r - xs;
      z_nxt = z_r + at;
    end
    last = (i_r == STEP_W'(CORDIC_STEPS - 1));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      i_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        i_r    <= '0;
      end else if (busy_r) begin
        i_r <= i_r + STEP_W'(1);
        if (last) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      x_r <= $signed(CORDIC_GAIN);
      y_r <= '0;
      z_r <= z0;
    end else if (busy_r) begin
      x_r <= x_nxt;
      y_r <= y_nxt;
      z_r <= z_nxt;
    end
  end

  assign x    = x_r;
  assign y    = y_r;
  assign done = done_r;

endmodule

// File: rtl/sosg_checker.sv
// Port-level assertions for the sine oscillator sample generator, bound to the top level.
module sosg_checker (
  input logic                                  clk,
  input logic                                  rst_n,
  input logic                                  in_valid,
  input logic                                  in_stall,
  input logic                                  out_valid,
  input logic                                  out_stall,
  input logic signed [sosg_pkg::SAMPLE_BITS-1:0] out_sample
);
  import sosg_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample))
    else $error("stalled result item changed or dropped");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall |=> in_stall)
    else $error("input taken again right after an accepted item");

  a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
    rst_n && in_valid && !in_stall && !out_valid |=> !out_valid)
    else $error("result item appeared one cycle after acceptance");

  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_stall)
    else $error("block not idle and empty after reset");

endmodule

bind sine_oscillator_sample_generator sosg_checker u_sosg_checker (.*);

// File: verif/tb_sine_oscillator_sample_generator.sv
// Testbench for the sine oscillator: bit-exact CORDIC predictor, random handshakes, config phases.
`timescale 1ns / 100ps

module tb_sine_oscillator_sample_generator;
  import sosg_pkg::*;

  typedef longint unsigned u64_t;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = CFG_IDX_W'(3);
  localparam longint               UNIT_Q30    = 64'sd1073741824;
  localparam int                   ANGLE_STEPS = 30;

  logic                          clk = 1'b0;
  logic                          rst_n = 1'b0;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic                          in_restart = 1'b0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic signed [SAMPLE_BITS-1:0] out_sample;
  logic                          cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]          cfg_index = '0;
  logic [CFG_W-1:0]              cfg_data = '0;

  // oscillator state as the block should hold it
  logic [PHASE_BITS-1:0]         osc_phase;
  logic [INC_W-1:0]              osc_inc;
  logic [AMP_W-1:0]              osc_amp;

  logic signed [SAMPLE_BITS-1:0] expected_samples[$];

  int unsigned errors = 0;
  int unsigned samples_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned restarts_sent = 0;
  int unsigned reg_writes = 0;
  int unsigned stall_left = 0;
  bit          out_stall_on = 1'b1;

  sine_oscillator_sample_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_sample (out_sample),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  initial begin
    #20000000;
    $display("simulation failed");
    $finish;
  end

  function automatic int unsigned arctan_step(input int k);
    case (k)
      0:  return 32'h3243F6A8;
      1:  return 32'h1DAC6705;
      2:  return 32'h0FADBAFC;
      3:  return 32'h07F56EA6;
      4:  return 32'h03FEAB76;
      5:  return 32'h01FFD55B;
      6:  return 32'h00FFFAAA;
      7:  return 32'h007FFF55;
      8:  return 32'h003FFFEA;
      9:  return 32'h001FFFFD;
      10: return 32'h000FFFFF;
      11: return 32'h0007FFFF;
      12: return 32'h0003FFFF;
      13: return 32'h0001FFFF;
      14: return 32'h0000FFFF;
      15: return 32'h00007FFF;
      16: return 32'h00003FFF;
      17: return 32'h00001FFF;
      18: return 32'h00000FFF;
      19: return 32'h000007FF;
      20: return 32'h000003FF;
      21: return 32'h000001FF;
      22: return 32'h000000FF;
      23: return 32'h0000007F;
      24: return 32'h0000003F;
      25: return 32'h0000001F;
      26: return 32'h0000000F;
      27: return 32'h00000008;
      28: return 32'h00000004;
      29: return 32'h00000002;
      default: return 0;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] sine_of_phase(
      input logic [PHASE_BITS-1:0] ph, input logic [AMP_W-1:0] gain);
    logic [63:0] aligned;
    logic [31:0] turn;
    u64_t        frac;
    u64_t        g;
    u64_t        mag;
    longint      x;
    longint      y;
    longint      z;
    longint      xs;
    longint      ys;
    longint      m;
    aligned = {ph, {(64 - PHASE_BITS){1'b0}}};
    turn = aligned[63:32];
    frac = u64_t'(turn[29:0]);
    z = longint'((frac * 64'h6487ED51) >> 30);
    x = 64'sh26DD3B6A;
    y = 0;
    for (int k = 0; k < ANGLE_STEPS; k++) begin
      xs = x >>> k;
      ys = y >>> k;
      if (z >= 0) begin
        x = x - ys;
        y = y + xs;
        z = z - longint'(arctan_step(k));
      end else begin
        x = x + ys;
        y = y - xs;
        z = z + longint'(arctan_step(k));
      end
    end
    m = turn[30] ? x : y;
    if (m < 0) m = 0;
    if (m > UNIT_Q30) m = UNIT_Q30;
    g = u64_t'(gain);
    g = (g * u64_t'(m)) >> 16;
    mag = (g * ((64'd1 << (SAMPLE_BITS - 1)) - 64'd1)) >> 30;
    if (turn[31]) mag = -mag;
    return SAMPLE_BITS'(mag);
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    roll = $urandom_range(99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 4);
    if (roll < 97) return $urandom_range(5, 40);
    return $urandom_range(60, 150);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_stall_on && $urandom_range(99) < 30) begin
      stall_left <= pick_gap();
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin : check_samples
    logic signed [SAMPLE_BITS-1:0] want;
    if (rst_n && out_valid === 1'b1 && !out_stall) begin
      if (expected_samples.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected sample %0d", out_sample);
      end else begin
        want = expected_samples.pop_front();
        samples_checked++;
        if (out_sample !== want) begin
          errors++;
          if (errors <= 10)
            $display("sample %0d: expected %0d got %0d", samples_checked, want, out_sample);
        end
      end
    end
  end

  // gap cycles with valid low, then hold the item until it is taken
  task automatic send_item(input bit restart_bit, input int unsigned gap);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart_bit;
    do @(posedge clk); while (in_stall);
    if (restart_bit) begin
      osc_phase = '0;
      restarts_sent++;
    end
    expected_samples.push_back(sine_of_phase(osc_phase, osc_amp));
    osc_phase = osc_phase + PHASE_BITS'(osc_inc);
    requests_sent++;
  endtask

  task automatic wait_results_done();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_samples.size() != 0);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    wait_results_done();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_PHASE_INC: osc_inc = value[INC_W-1:0];
      REG_AMPLITUDE: osc_amp = value[AMP_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic test_reset_values();
    send_item(1'b0, 0);
    send_item(1'b0, 0);
    send_item(1'b0, 3);
    send_item(1'b1, 0);
  endtask

  // exact quadrant points, then phases just below a full turn
  task automatic test_quadrant_points();
    write_reg(REG_PHASE_INC, 32'h4000_0000);
    write_reg(REG_AMPLITUDE, 32'h0000_FFFF);
    repeat (2) send_item(1'b1, 0);
    repeat (3) send_item(1'b0, 0);
    write_reg(REG_PHASE_INC, 32'hFFFF_FFFF);
    send_item(1'b1, 0);
    repeat (2) send_item(1'b0, 0);
  endtask

  task automatic test_gain_extremes();
    write_reg(REG_PHASE_INC, 32'h8000_0000);
    write_reg(REG_AMPLITUDE, 32'h0000_0000);
    send_item(1'b1, 0);
    repeat (2) send_item(1'b0, 1);
    write_reg(REG_PHASE_INC, 32'h2AAA_AAAB);
    write_reg(REG_AMPLITUDE, 32'hABCD_FFFF);
    repeat (3) send_item(1'b0, 0);
  endtask

  // zero step holds the phase, so the output stays constant until the restart clears it
  task automatic test_zero_increment();
    write_reg(REG_PHASE_INC, 32'h0000_0000);
    write_reg(REG_AMPLITUDE, 32'h0000_C000);
    send_item(1'b0, 0);
    send_item(1'b0, 0);
    send_item(1'b1, 0);
  endtask

  task automatic test_unused_index();
    write_reg(REG_PHASE_INC, 32'h0123_4567);
    write_reg(REG_SPARE_A, $urandom);
    write_reg(REG_SPARE_B, $urandom);
    repeat (3) send_item(1'b0, 0);
  endtask

  task automatic test_random_streams();
    logic [INC_W-1:0] inc_val;
    logic [AMP_W-1:0] amp_val;
    bit               sides_idle;
    for (int p = 0; p < 10; p++) begin
      case ($urandom_range(3))
        0: inc_val = $urandom_range(1, 2000);
        1: inc_val = $urandom;
        2: inc_val = $urandom_range(1 << 20, 1 << 27);
        default: inc_val = {8'($urandom_range(1, 255)), 24'h0};
      endcase
      amp_val = ($urandom_range(3) == 0) ? AMP_W'($urandom_range(1, 255)) : AMP_W'($urandom);
      if (p == 0) begin
        inc_val = 32'h0000_0001;
        amp_val = 16'hFFFF;
      end
      if (p == 1) begin
        inc_val = 32'h8000_0000;
        amp_val = 16'h0001;
      end
      if (p == 2) inc_val = 32'hFFFF_FFFF;
      write_reg(REG_PHASE_INC, inc_val);
      write_reg(REG_AMPLITUDE, {16'($urandom), amp_val});
      sides_idle = (p % 4 != 1);
      out_stall_on = sides_idle;
      for (int n = 0; n < 85; n++) begin
        send_item($urandom_range(15) == 0, sides_idle ? pick_gap() : 0);
        if (n == 42 && p % 3 == 0) wait_results_done();
      end
    end
    out_stall_on = 1'b1;
  endtask

  initial begin
    osc_phase = '0;
    osc_inc = 32'd89478485;
    osc_amp = 16'd32768;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_values();
    test_quadrant_points();
    test_gain_extremes();
    test_zero_increment();
    test_unused_index();
    test_random_streams();
    wait_results_done();
    repeat (40) @(posedge clk);
    $display("covered %0d sample requests (%0d with restart) over %0d register writes",
             requests_sent, restarts_sent, reg_writes);
    $display("%0d samples compared, %0d errors", samples_checked, errors);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
